// ===== src/kd_pkg.sv =====
// Package for the key debouncer with long press and auto repeat.
// Holds the key count, timing register layout, mode and action codes.
// No dependencies; every module of the block imports it.
package kd_pkg;

	localparam int KEY_COUNT = 4;
	localparam int KEY_W     = $clog2(KEY_COUNT);
	localparam int FILT_W    = 8;
	localparam int HOLD_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [1:0] {
		MODE_FREE      = 2'd0,
		MODE_WAIT_LONG = 2'd1,
		MODE_COOLDOWN  = 2'd2,
		MODE_REPEAT    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ACT_PUSH         = 3'd0,
		ACT_LONG         = 3'd1,
		ACT_REPEAT       = 3'd2,
		ACT_RELEASE      = 3'd3,
		ACT_RELEASE_LONG = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER   = 2'd0,
		REG_LONG     = 2'd1,
		REG_COOLDOWN = 2'd2,
		REG_INTERVAL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [FILT_W-1:0] filter_ticks;
		logic [HOLD_W-1:0] long_press_ticks;
		logic [HOLD_W-1:0] repeat_cooldown_ticks;
		logic [HOLD_W-1:0] repeat_interval_ticks;
	} cfg_t;

	typedef struct packed {
		logic    valid;
		action_t action;
	} evt_t;

endpackage

// ===== src/kd_lane.sv =====
// One key lane: debounce, hold and repeat state of a single key.
// Computes the key's event for a tick and updates its state on accept.
// Depends on kd_pkg.
module kd_lane import kd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic active,
	input  cfg_t cfg,
	output evt_t evt
);

	mode_t             mode_q, mode_d;
	logic [FILT_W-1:0] deb_q, deb_d;
	logic [HOLD_W-1:0] hold_q, hold_d;
	logic [HOLD_W-1:0] hold_inc;

	assign hold_inc = hold_q + HOLD_W'(1);

	always_comb begin
		mode_d     = mode_q;
		deb_d      = deb_q;
		hold_d     = hold_q;
		evt.valid  = 1'b0;
		evt.action = ACT_PUSH;
		if (active) begin
			if (mode_q == MODE_FREE) begin
				if (deb_q >= cfg.filter_ticks) begin
					evt.valid  = 1'b1;
					evt.action = ACT_PUSH;
					mode_d     = MODE_WAIT_LONG;
					hold_d     = '0;
				end else begin
					deb_d = deb_q + FILT_W'(1);
				end
			end else begin
				deb_d  = cfg.filter_ticks;
				hold_d = hold_inc;
				if (mode_q == MODE_WAIT_LONG && hold_inc == cfg.long_press_ticks) begin
					evt.valid  = 1'b1;
					evt.action = ACT_LONG;
					mode_d     = (cfg.repeat_cooldown_ticks != '0) ? MODE_COOLDOWN : MODE_REPEAT;
					hold_d     = '0;
				end else if (cfg.repeat_interval_ticks != '0) begin
					if (mode_q == MODE_COOLDOWN && hold_inc == cfg.repeat_cooldown_ticks) begin
						evt.valid  = 1'b1;
						evt.action = ACT_REPEAT;
						mode_d     = MODE_REPEAT;
						hold_d     = '0;
					end else if (mode_q == MODE_REPEAT
							&& hold_inc == cfg.repeat_interval_ticks) begin
						evt.valid  = 1'b1;
						evt.action = ACT_REPEAT;
						hold_d     = '0;
					end
				end
			end
		end else if (mode_q != MODE_FREE) begin
			if (deb_q == '0) begin
				evt.valid  = 1'b1;
				evt.action = (mode_q == MODE_WAIT_LONG) ? ACT_RELEASE : ACT_RELEASE_LONG;
				mode_d     = MODE_FREE;
			end else begin
				deb_d = deb_q - FILT_W'(1);
			end
		end else begin
			deb_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FREE;
			deb_q  <= '0;
			hold_q <= '0;
		end else if (en) begin
			mode_q <= mode_d;
			deb_q  <= deb_d;
			hold_q <= hold_d;
		end
	end

endmodule

// ===== src/kd_merge.sv =====
// Merging stage: holds one tick's lane events and sends them in key order.
// Feeds an output register and stalls the input while older events wait.
// Depends on kd_pkg.
module kd_merge import kd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  evt_t                evts [KEY_COUNT],
	input  logic                out_stall,
	output logic                in_stall,
	output logic                pend_any,
	output logic                out_valid,
	output logic [KEY_W-1:0]    key_index,
	output action_t             action,
	output logic                last_event
);

	logic [KEY_COUNT-1:0] pend_q;
	action_t              act_q [KEY_COUNT];
	logic [KEY_COUNT-1:0] rest;
	logic [KEY_W-1:0]     sel;
	logic                 pop_ok;
	logic                 pop;
	logic                 out_valid_q;
	logic [KEY_W-1:0]     key_index_q;
	action_t              action_q;
	logic                 last_q;

	always_comb begin
		sel = '0;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel = KEY_W'(k);
			end
		end
	end

	assign rest     = pend_q & ~(KEY_COUNT'(1) << sel);
	assign pend_any = |pend_q;
	assign pop_ok   = !out_valid_q || !out_stall;
	assign pop      = pop_ok && pend_any;
	assign in_stall = pend_any && !(pop && rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				for (int k = 0; k < KEY_COUNT; k++) begin
					pend_q[k] <= evts[k].valid;
				end
			end else if (pop) begin
				pend_q <= rest;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				act_q[k] <= evts[k].action;
			end
		end
		if (pop) begin
			key_index_q <= sel;
			action_q    <= act_q[sel];
			last_q      <= (rest == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign key_index  = key_index_q;
	assign action     = action_q;
	assign last_event = last_q;

endmodule

// ===== src/key_debounce_long_press_repeat.sv =====
// Top level of the four-key debouncer with long press and auto repeat.
// Instantiates kd_lane per key and kd_merge; depends on kd_pkg.
//
// Usage:
//   Input channel: key_levels with in_valid / in_stall; one beat is one tick
//   of the slow timer, bit i high when key i is active.
//   Output channel: key_index, action, last_event with out_valid / out_stall;
//   one beat per event, events of a tick in key order, the final one marked
//   by last_event. A tick that causes no event gives no beat.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; the
//   ready is always high. Write only while no events are outstanding.
// Path: the first event of a tick passes the event buffer, then the output
// register. Throughput: one tick per cycle when ticks cause at most one
// event and the receiver does not stall; a tick with several events holds the
// event buffer while the single output register drains one event per cycle.
// Reset clears every key to free with zero counts and loads the timing
// registers with 5, 1000, 500 and 200. When the receiver stalls, the output
// beat holds, remaining events wait in the buffer and in_stall rises once a
// new tick could not be taken in.
module key_debounce_long_press_repeat import kd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KEY_COUNT-1:0] key_levels,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KEY_W-1:0]     key_index,
	output logic [2:0]           action,
	output logic                 last_event,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	evt_t    evts [KEY_COUNT];
	logic    accept;
	logic    pend_any;
	action_t action_w;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_ticks          <= FILT_W'(5);
			cfg_q.long_press_ticks      <= HOLD_W'(1000);
			cfg_q.repeat_cooldown_ticks <= HOLD_W'(500);
			cfg_q.repeat_interval_ticks <= HOLD_W'(200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FILTER:   cfg_q.filter_ticks          <= cfg_data[FILT_W-1:0];
				REG_LONG:     cfg_q.long_press_ticks      <= cfg_data[HOLD_W-1:0];
				REG_COOLDOWN: cfg_q.repeat_cooldown_ticks <= cfg_data[HOLD_W-1:0];
				REG_INTERVAL: cfg_q.repeat_interval_ticks <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
		kd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.active (key_levels[k]),
			.cfg    (cfg_q),
			.evt    (evts[k])
		);
	end

	kd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.evts       (evts),
		.out_stall  (out_stall),
		.in_stall   (in_stall),
		.pend_any   (pend_any),
		.out_valid  (out_valid),
		.key_index  (key_index),
		.action     (action_w),
		.last_event (last_event)
	);

	assign action = action_w;

	// A stall toward the source only comes from events still in the buffer.
	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pend_any)
		else $error("input stalled with an empty event buffer");

	// An event that is not the last of its tick leaves more events behind.
	a_more_after_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_event) |-> pend_any)
		else $error("non-final event with nothing left to send");

	// Action codes above the release-after-long-press code never leave the block.
	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= 3'd4))
		else $error("undefined action code on the output");

endmodule
